>>> hdl/ascii_date_to_epoch_units_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the ASCII date to epoch units block
// Each use expands to one labeled concurrent assertion on clk, off in reset.
// ---------------------------------------------------------------------------
`ifndef ASCII_DATE_TO_EPOCH_UNITS_TOP_DEFINES_SVH
`define ASCII_DATE_TO_EPOCH_UNITS_TOP_DEFINES_SVH

// Same-cycle implication.
`define ADTE_ASSERT_IMPL(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("adte: same-cycle check failed");

// Next-cycle implication.
`define ADTE_ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("adte: next-cycle check failed");

`endif

>>> hdl/adte_pkg.sv
// ---------------------------------------------------------------------------
// adte_pkg
// Constants, codes and small lookup functions of the date to epoch block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package adte_pkg;

    // Register indexes
    localparam logic CFG_TIME_UNIT = 1'b0;
    localparam logic CFG_UNIT_DIV  = 1'b1;

    // Time unit codes
    localparam logic [3:0] UNIT_YEAR  = 4'd0;
    localparam logic [3:0] UNIT_MONTH = 4'd1;
    localparam logic [3:0] UNIT_WEEK  = 4'd2;
    localparam logic [3:0] UNIT_DAY   = 4'd3;
    localparam logic [3:0] UNIT_HOUR  = 4'd4;
    localparam logic [3:0] UNIT_MIN   = 4'd5;
    localparam logic [3:0] UNIT_SEC   = 4'd6;
    localparam logic [3:0] UNIT_MS    = 4'd7;
    localparam logic [3:0] UNIT_US    = 4'd8;
    localparam logic [3:0] UNIT_NS    = 4'd9;
    localparam logic [3:0] UNIT_PS    = 4'd10;
    localparam logic [3:0] UNIT_FS    = 4'd11;
    localparam logic [3:0] UNIT_AS    = 4'd12;

    // ASCII characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic signed [15:0] YEAR_BASE = 16'sd1970;
    localparam logic signed [7:0]  MAX_MONTH = 8'sd12;
    // floor(x/100) == (x * 5243) >> 19 for x below 40000
    localparam logic [12:0] RECIP100 = 13'd5243;
    // floor(x/7) == (x * 9586981) >> 26 for x below 2^23
    localparam logic signed [32:0] RECIP7 = 33'sd9586981;
    localparam logic [63:0] NAT_VALUE = 64'h8000_0000_0000_0000;

    // Decimal parse of up to four bytes, first byte in bits 31..24.
    function automatic logic signed [14:0] parse_dec(input logic [31:0] b,
                                                     input logic four);
        logic [7:0]  c;
        logic        ws;
        logic        started;
        logic        done;
        logic        neg;
        logic [13:0] v;
        logic [2:0]  nb;
        nb      = four ? 3'd4 : 3'd2;
        started = 1'b0;
        done    = 1'b0;
        neg     = 1'b0;
        v       = '0;
        for (int i = 0; i < 4; i++)
        begin
            c  = b[31 - 8*i -: 8];
            ws = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
            if (3'(i) < nb && !done && !(!started && ws))
            begin
                if (!started && (c == CH_PLUS || c == CH_MINUS))
                begin
                    neg     = (c == CH_MINUS);
                    started = 1'b1;
                end
                else if (c >= CH_0 && c <= CH_9)
                begin
                    v       = 14'(v * 14'd10 + 14'(c - CH_0));
                    started = 1'b1;
                end
                else
                begin
                    done = 1'b1;
                end
            end
        end
        return neg ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

    // Days in the whole months before month m of a common year.
    function automatic logic [8:0] month_cum(input logic [3:0] m);
        case (m)
            4'd2:    return 9'd31;
            4'd3:    return 9'd59;
            4'd4:    return 9'd90;
            4'd5:    return 9'd120;
            4'd6:    return 9'd151;
            4'd7:    return 9'd181;
            4'd8:    return 9'd212;
            4'd9:    return 9'd243;
            4'd10:   return 9'd273;
            4'd11:   return 9'd304;
            4'd12:   return 9'd334;
            default: return 9'd0;
        endcase
    endfunction

    // Units per day, modulo 2^64.
    function automatic logic [63:0] unit_factor(input logic [3:0] u);
        case (u)
            UNIT_HOUR: return 64'd24;
            UNIT_MIN:  return 64'd1440;
            UNIT_SEC:  return 64'd86400;
            UNIT_MS:   return 64'd86400000;
            UNIT_US:   return 64'd86400000000;
            UNIT_NS:   return 64'd86400000000000;
            UNIT_PS:   return 64'd86400000000 * 64'd1000000;
            UNIT_FS:   return 64'd86400000000 * 64'd1000000 * 64'd1000;
            UNIT_AS:   return 64'd86400000000 * 64'd1000000 * 64'd1000000;
            default:   return 64'd1;
        endcase
    endfunction

endpackage

`default_nettype wire

>>> hdl/ascii_date_to_epoch_units_top.sv
// ---------------------------------------------------------------------------
// ascii_date_to_epoch_units_top
// Streams YYYYMMDD ASCII dates in and signed epoch counts in a chosen unit out.
// ---------------------------------------------------------------------------
// One date beat enters per clock and one result beat leaves per clock unless
// a result is held; each result runs through the 64-stage bit-per-stage
// restoring divider that applies unit_divisor. Eight stages before it parse
// the year, month and day text (leading white space, optional sign, digits up
// to the first other byte), form days since 1970-01-01 with truncating leap
// corrections, and scale to the unit through a shared 26x33 multiplier plus a
// 26x32 high-half product (wrap modulo 2^64). A month above twelve or a unit
// code above twelve gives not-a-time: tdata is the minimum 64-bit value and
// tuser is set. Backpressure freezes every stage together, so a stall loses
// or repeats nothing. Write time_unit and unit_divisor only while idle.
`timescale 1ns / 1ps
`default_nettype none
`include "ascii_date_to_epoch_units_top_defines.svh"

module ascii_date_to_epoch_units_top
    import adte_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [30:0] cfg_data,
    // input beat
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // year_chars[31:0], month_chars[47:32], day_chars[63:48]
    // result beat
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // epoch_value[63:0]
    output logic             m_tuser    // not_a_time[0]
);

    localparam int DIV_STAGES = 64;

    // Configuration registers
    logic [3:0]  time_unit_reg;
    logic [30:0] unit_divisor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_unit_reg    <= UNIT_DAY;
            unit_divisor_reg <= 31'd1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_TIME_UNIT)
                time_unit_reg <= cfg_data[3:0];
            else
                unit_divisor_reg <= cfg_data;
        end
    end

    // Unit constants; the user must keep them stable while items are in flight, the block does not enforce it
    logic [63:0] factor;
    logic        is_week;
    logic        is_year;
    logic        is_month;
    logic [30:0] div_eff;

    assign factor   = unit_factor(time_unit_reg);
    assign is_week  = (time_unit_reg == UNIT_WEEK);
    assign is_year  = (time_unit_reg == UNIT_YEAR);
    assign is_month = (time_unit_reg == UNIT_MONTH);
    // A divisor of zero or one passes the value through as a divide by one
    assign div_eff  = (unit_divisor_reg > 31'd1) ? unit_divisor_reg : 31'd1;

    // Whole pipe advances together unless the result beat is held
    logic adv;
    logic out_valid_reg;
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    // -----------------------------------------------------------------------
    // Stage 1: parse text fields
    // -----------------------------------------------------------------------
    logic                 p1_valid_reg, p1_valid_next;
    logic signed [14:0]   p1_y_reg, p1_y_next;
    logic signed [7:0]    p1_m_reg, p1_m_next;
    logic signed [7:0]    p1_d_reg, p1_d_next;
    logic                 p1_nat_reg, p1_nat_next;

    always_comb
    begin
        p1_valid_next = s_tvalid;
        p1_y_next     = parse_dec(s_tdata[31:0], 1'b1);
        p1_m_next     = 8'(parse_dec({s_tdata[47:32], 16'h0000}, 1'b0));
        p1_d_next     = 8'(parse_dec({s_tdata[63:48], 16'h0000}, 1'b0));
        p1_nat_next   = (p1_m_next > MAX_MONTH) || (time_unit_reg > UNIT_AS);
    end

    // -----------------------------------------------------------------------
    // Stage 2: year offset and numerators of the leap corrections
    // -----------------------------------------------------------------------
    logic                 p2_valid_reg;
    logic signed [15:0]   p2_yr_reg, p2_yr_next;
    logic                 p2_pos_reg, p2_pos_next;
    logic [13:0]          p2_n4_reg, p2_n4_next;
    logic [13:0]          p2_n100_reg, p2_n100_next;
    logic [13:0]          p2_n400_reg, p2_n400_next;
    logic [13:0]          p2_ay_reg, p2_ay_next;
    logic                 p2_ylz_reg, p2_ylz_next;
    logic [8:0]           p2_cum_reg, p2_cum_next;
    logic                 p2_ge3_reg, p2_ge3_next;
    logic signed [7:0]    p2_m_reg;
    logic signed [7:0]    p2_d_reg;
    logic                 p2_nat_reg;

    always_comb
    begin
        p2_yr_next   = 16'(p1_y_reg) - YEAR_BASE;
        p2_pos_next  = !p2_yr_next[15];
        // Nonnegative days round the corrections up from later years,
        // negative ones from earlier years; both truncate toward zero
        p2_n4_next   = p2_pos_next ? 14'(p2_yr_next + 16'sd1)   : 14'(16'sd2 - p2_yr_next);
        p2_n100_next = p2_pos_next ? 14'(p2_yr_next + 16'sd69)  : 14'(16'sd30 - p2_yr_next);
        p2_n400_next = p2_pos_next ? 14'(p2_yr_next + 16'sd369) : 14'(16'sd30 - p2_yr_next);
        p2_ay_next   = p1_y_reg[14] ? 14'(-p1_y_reg) : 14'(p1_y_reg);
        p2_ylz_next  = (p1_y_reg[1:0] == 2'b00);
        p2_cum_next  = month_cum((p1_m_reg < 8'sd1) ? 4'd0 : p1_m_reg[3:0]);
        p2_ge3_next  = (p1_m_reg >= 8'sd3);
    end

    // -----------------------------------------------------------------------
    // Stage 3: reciprocal products for the divides by 100 and 400
    // -----------------------------------------------------------------------
    logic                 p3_valid_reg;
    logic signed [23:0]   p3_yr365_reg, p3_yr365_next;
    logic [11:0]          p3_q4_reg, p3_q4_next;
    logic [7:0]           p3_q100_reg, p3_q100_next;
    logic [5:0]           p3_q400_reg, p3_q400_next;
    logic [6:0]           p3_qy_reg, p3_qy_next;
    logic [26:0]          m100, m400, my;
    logic [13:0]          p3_ay_reg;
    logic                 p3_ylz_reg;
    logic [8:0]           p3_cum_reg;
    logic                 p3_ge3_reg;
    logic                 p3_pos_reg;
    logic signed [15:0]   p3_yr_reg;
    logic signed [7:0]    p3_m_reg;
    logic signed [7:0]    p3_d_reg;
    logic                 p3_nat_reg;

    always_comb
    begin
        m100          = 27'(p2_n100_reg) * 27'(RECIP100);
        m400          = 27'(p2_n400_reg) * 27'(RECIP100);
        my            = 27'(p2_ay_reg) * 27'(RECIP100);
        p3_yr365_next = 24'(p2_yr_reg) * 24'sd365;
        p3_q4_next    = p2_n4_reg[13:2];
        p3_q100_next  = m100[26:19];
        p3_q400_next  = m400[26:21];
        p3_qy_next    = my[25:19];
    end

    // -----------------------------------------------------------------------
    // Stage 4: base day count, leap flag, month offset
    // -----------------------------------------------------------------------
    logic                 p4_valid_reg;
    logic signed [23:0]   p4_base_reg, p4_base_next;
    logic [8:0]           p4_extra_reg, p4_extra_next;
    logic signed [23:0]   p4_mval_reg, p4_mval_next;
    logic                 leap;
    logic signed [15:0]   p4_yr_reg;
    logic signed [7:0]    p4_d_reg;
    logic                 p4_nat_reg;

    always_comb
    begin
        if (p3_pos_reg)
            p4_base_next = p3_yr365_reg + 24'(p3_q4_reg) - 24'(p3_q100_reg)
                           + 24'(p3_q400_reg);
        else
            p4_base_next = p3_yr365_reg - 24'(p3_q4_reg) + 24'(p3_q100_reg)
                           - 24'(p3_q400_reg);
        leap          = p3_ylz_reg && ((p3_ay_reg != 14'(p3_qy_reg) * 14'd100)
                                       || (p3_qy_reg[1:0] == 2'b00));
        p4_extra_next = p3_cum_reg + 9'(leap && p3_ge3_reg);
        p4_mval_next  = 24'(p3_yr_reg) * 24'sd12 + 24'(p3_m_reg) - 24'sd1;
    end

    // -----------------------------------------------------------------------
    // Stage 5: value in whole years, months or days
    // -----------------------------------------------------------------------
    logic                 p5_valid_reg;
    logic signed [25:0]   p5_val_reg, p5_val_next;
    logic                 p5_nat_reg;

    always_comb
    begin
        if (is_year)
            p5_val_next = 26'(p4_yr_reg);
        else if (is_month)
            p5_val_next = 26'(p4_mval_reg);
        else
            p5_val_next = 26'(p4_base_reg) + 26'(p4_extra_reg) + 26'(p4_d_reg) - 26'sd1;
    end

    // -----------------------------------------------------------------------
    // Stage 6: shared multiplier (low factor half, or reciprocal of 7)
    // -----------------------------------------------------------------------
    logic                 p6_valid_reg;
    logic signed [58:0]   p6_prod_reg, p6_prod_next;
    logic signed [25:0]   p6_val_reg;
    logic                 p6_neg_reg, p6_neg_next;
    logic                 p6_nat_reg;
    logic signed [25:0]   op_a;
    logic signed [32:0]   op_b;

    always_comb
    begin
        p6_neg_next  = p5_val_reg[25];
        // Floor of a negative week count is minus the ceiling of its magnitude
        if (is_week)
        begin
            op_a = p6_neg_next ? (-p5_val_reg + 26'sd6) : p5_val_reg;
            op_b = RECIP7;
        end
        else
        begin
            op_a = p5_val_reg;
            op_b = $signed({1'b0, factor[31:0]});
        end
        p6_prod_next = 59'(op_a) * 59'(op_b);
    end

    // -----------------------------------------------------------------------
    // Stage 7: high factor half and wrap to 64 bits
    // -----------------------------------------------------------------------
    logic                 p7_valid_reg;
    logic [63:0]          p7_t_reg, p7_t_next;
    logic                 p7_nat_reg;
    logic [31:0]          phi;
    logic [20:0]          wq;

    always_comb
    begin
        phi = 32'(32'(p6_val_reg) * factor[63:32]);
        wq  = p6_prod_reg[46:26];
        if (is_week)
            p7_t_next = p6_neg_reg ? (64'd0 - 64'(wq)) : 64'(wq);
        else
            p7_t_next = 64'(p6_prod_reg) + {phi, 32'h0000_0000};
    end

    // -----------------------------------------------------------------------
    // Stage 8: magnitude for the divider
    // -----------------------------------------------------------------------
    logic                 p8_valid_reg;
    logic [63:0]          p8_a_reg, p8_a_next;
    logic                 p8_neg_reg;
    logic                 p8_nat_reg;

    assign p8_a_next = p7_t_reg[63] ? (64'd0 - p7_t_reg) : p7_t_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
            p6_valid_reg <= 1'b0;
            p7_valid_reg <= 1'b0;
            p8_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg <= p1_valid_next;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            p5_valid_reg <= p4_valid_reg;
            p6_valid_reg <= p5_valid_reg;
            p7_valid_reg <= p6_valid_reg;
            p8_valid_reg <= p7_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_y_reg     <= p1_y_next;
            p1_m_reg     <= p1_m_next;
            p1_d_reg     <= p1_d_next;
            p1_nat_reg   <= p1_nat_next;

            p2_yr_reg    <= p2_yr_next;
            p2_pos_reg   <= p2_pos_next;
            p2_n4_reg    <= p2_n4_next;
            p2_n100_reg  <= p2_n100_next;
            p2_n400_reg  <= p2_n400_next;
            p2_ay_reg    <= p2_ay_next;
            p2_ylz_reg   <= p2_ylz_next;
            p2_cum_reg   <= p2_cum_next;
            p2_ge3_reg   <= p2_ge3_next;
            p2_m_reg     <= p1_m_reg;
            p2_d_reg     <= p1_d_reg;
            p2_nat_reg   <= p1_nat_reg;

            p3_yr365_reg <= p3_yr365_next;
            p3_q4_reg    <= p3_q4_next;
            p3_q100_reg  <= p3_q100_next;
            p3_q400_reg  <= p3_q400_next;
            p3_qy_reg    <= p3_qy_next;
            p3_ay_reg    <= p2_ay_reg;
            p3_ylz_reg   <= p2_ylz_reg;
            p3_cum_reg   <= p2_cum_reg;
            p3_ge3_reg   <= p2_ge3_reg;
            p3_pos_reg   <= p2_pos_reg;
            p3_yr_reg    <= p2_yr_reg;
            p3_m_reg     <= p2_m_reg;
            p3_d_reg     <= p2_d_reg;
            p3_nat_reg   <= p2_nat_reg;

            p4_base_reg  <= p4_base_next;
            p4_extra_reg <= p4_extra_next;
            p4_mval_reg  <= p4_mval_next;
            p4_yr_reg    <= p3_yr_reg;
            p4_d_reg     <= p3_d_reg;
            p4_nat_reg   <= p3_nat_reg;

            p5_val_reg   <= p5_val_next;
            p5_nat_reg   <= p4_nat_reg;

            p6_prod_reg  <= p6_prod_next;
            p6_val_reg   <= p5_val_reg;
            p6_neg_reg   <= p6_neg_next;
            p6_nat_reg   <= p5_nat_reg;

            p7_t_reg     <= p7_t_next;
            p7_nat_reg   <= p6_nat_reg;

            p8_a_reg     <= p8_a_next;
            p8_neg_reg   <= p7_t_reg[63];
            p8_nat_reg   <= p7_nat_reg;
        end
    end

    // -----------------------------------------------------------------------
    // Divider: one quotient bit per stage, quotient shifts in as the
    // dividend shifts out of the same word
    // -----------------------------------------------------------------------
    logic        dv_valid_reg [0:DIV_STAGES-1];
    logic [30:0] dv_rem_reg   [0:DIV_STAGES-1];
    logic [63:0] dv_num_reg   [0:DIV_STAGES-1];
    logic        dv_neg_reg   [0:DIV_STAGES-1];
    logic        dv_nat_reg   [0:DIV_STAGES-1];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        logic        valid_in;
        logic [30:0] rem_in;
        logic [63:0] num_in;
        logic        neg_in;
        logic        nat_in;
        logic [31:0] trial;
        logic        fits;
        logic [30:0] rem_next;
        logic [63:0] num_next;

        if (k == 0)
        begin : g_first
            assign valid_in = p8_valid_reg;
            assign rem_in   = '0;
            assign num_in   = p8_a_reg;
            assign neg_in   = p8_neg_reg;
            assign nat_in   = p8_nat_reg;
        end
        else
        begin : g_next
            assign valid_in = dv_valid_reg[k-1];
            assign rem_in   = dv_rem_reg[k-1];
            assign num_in   = dv_num_reg[k-1];
            assign neg_in   = dv_neg_reg[k-1];
            assign nat_in   = dv_nat_reg[k-1];
        end

        assign trial    = {rem_in, num_in[63]};
        assign fits     = (trial >= {1'b0, div_eff});
        assign rem_next = fits ? 31'(trial - {1'b0, div_eff}) : trial[30:0];
        assign num_next = {num_in[62:0], fits};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[k] <= 1'b0;
            else if (adv)
                dv_valid_reg[k] <= valid_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_rem_reg[k] <= rem_next;
                dv_num_reg[k] <= num_next;
                dv_neg_reg[k] <= neg_in;
                dv_nat_reg[k] <= nat_in;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Output register: restore sign with floor rounding, apply not-a-time
    // -----------------------------------------------------------------------
    logic [63:0] out_data_reg, out_data_next;
    logic        out_nat_reg;
    logic [63:0] q_last;
    logic        rem_nz;

    assign q_last = dv_num_reg[DIV_STAGES-1];
    assign rem_nz = (dv_rem_reg[DIV_STAGES-1] != '0);

    always_comb
    begin
        if (dv_nat_reg[DIV_STAGES-1])
            out_data_next = NAT_VALUE;
        else if (dv_neg_reg[DIV_STAGES-1])
            out_data_next = 64'd0 - q_last - 64'(rem_nz);
        else
            out_data_next = q_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= dv_valid_reg[DIV_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
            out_nat_reg  <= dv_nat_reg[DIV_STAGES-1];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_nat_reg;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    // Not-a-time results carry the minimum value
    `ADTE_ASSERT_IMPL(a_nat_value, m_tvalid && m_tuser, m_tdata == NAT_VALUE)
    // An accepted beat lands in the first stage
    `ADTE_ASSERT_NEXT(a_enter, s_tvalid && s_tready, p1_valid_reg)
    // Input is refused only while a result is held
    `ADTE_ASSERT_IMPL(a_stall_only, !s_tready, m_tvalid && !m_tready)

endmodule

`default_nettype wire
